FILE: rtl/swm_pkg.sv
// shared types and constants for the sliding window median filter
// no dependencies; imported by swm_cell and sliding_window_median_top
`default_nettype none

package swm_pkg;

	// fixed widths of the ports
	localparam int DATA_W = 32;
	localparam int CFG_W  = 7;

	// per-cell flags seen by the neighbouring cells
	typedef struct packed {
		logic valid;  // cell holds a sample
		logic gt;     // empty, or held value above the incoming sample
		logic evict;  // cell holds the oldest sample of a full window; it leaves when a sample is accepted
	} cell_flags_t;

endpackage

`default_nettype wire

FILE: rtl/sliding_window_median_top.sv
// Sliding window median filter: takes one sample per clock while sample_ready is high
// and, once the window of window_size samples is full, returns the lower median of the
// window for every sample. The window is a row of WINDOW_MAX compare-and-shift cells
// kept in ascending order; a new sample is inserted and the oldest one removed in the
// same cycle, so the sustained rate is one sample per cycle while the output is not
// stalled. A result passes through the cell row and then the output register that
// reads the median cell. Writing window_size empties the window; no new results are
// produced until it refills. Depends on swm_pkg and swm_cell.
`default_nettype none

module sliding_window_median_top
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_W-1:0]  cfg_wr_data,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire logic [DATA_W-1:0] sample,
	output logic                   median_valid,
	input  wire logic              median_ready,
	output logic [DATA_W-1:0]      median
);

	localparam int N  = WINDOW_MAX;
	localparam int SW = SAMPLE_WIDTH;
	localparam int AW = (N > 1) ? $clog2(N) : 1;
	localparam int KW = $clog2(N + 1);

	logic [KW-1:0]     k_q;
	logic [AW-1:0]     age_lim_q;
	logic [AW-1:0]     med_idx_q;
	logic [KW-1:0]     fill_q;
	logic              pend_s1;
	logic              out_valid_q;
	logic [SW-1:0]     median_q;

	logic [KW-1:0]     k_new;
	logic [KW:0]       k_plus;
	logic [SW-1:0]     smp;
	logic              step;
	logic              full;
	logic              emit;
	logic              move;

	logic [SW-1:0]     cell_val [N];
	logic [AW-1:0]     cell_age [N];
	cell_flags_t       cell_flg [N];
	logic [N:0]        del_chain;
	logic [N-1:0]      valid_vec;

	// effective window size: zero counts as one, large values saturate
	always_comb begin
		if (cfg_wr_data == '0) begin
			k_new = KW'(1);
		end else if (32'(cfg_wr_data) > N) begin
			k_new = KW'(N);
		end else begin
			k_new = KW'(cfg_wr_data);
		end
		k_plus = {1'b0, k_new} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= KW'(1);
			age_lim_q <= '0;
			med_idx_q <= '0;
		end else if (cfg_wr_en) begin
			k_q       <= k_new;
			age_lim_q <= AW'(k_new - 1'b1);
			med_idx_q <= AW'((k_plus >> 1) - 1'b1);
		end
	end

	assign smp  = SW'(sample);
	assign step = sample_valid && sample_ready;
	assign full = (fill_q == k_q);
	assign emit = full || (KW'(fill_q + 1'b1) == k_q);

	// result pipeline: the cell row holds one pending result, the output register another
	assign move         = pend_s1 && (!out_valid_q || median_ready);
	assign sample_ready = !pend_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fill_q <= '0;
			end else if (step && !full) begin
				fill_q <= fill_q + 1'b1;
			end
			if (step) begin
				pend_s1 <= emit;
			end else if (move) begin
				pend_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (median_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			median_q <= cell_val[med_idx_q];
		end
	end

	assign median_valid = out_valid_q;
	assign median       = DATA_W'(median_q);

	assign del_chain[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [SW-1:0] l_val;
		logic [AW-1:0] l_age;
		cell_flags_t   l_flg;
		logic          l_fill;
		logic [SW-1:0] r_val;
		logic [AW-1:0] r_age;
		cell_flags_t   r_flg;

		if (i == 0) begin : g_left_edge
			assign l_val  = '0;
			assign l_age  = '0;
			assign l_flg  = '0;
			assign l_fill = 1'b1;
		end else begin : g_left
			assign l_val  = cell_val[i-1];
			assign l_age  = cell_age[i-1];
			assign l_flg  = cell_flg[i-1];
			assign l_fill = cell_flg[i-1].valid;
		end

		if (i == N - 1) begin : g_right_edge
			assign r_val = '0;
			assign r_age = '0;
			assign r_flg = '0;
		end else begin : g_right
			assign r_val = cell_val[i+1];
			assign r_age = cell_age[i+1];
			assign r_flg = cell_flg[i+1];
		end

		swm_cell #(
			.SW(SW),
			.AW(AW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clear     (cfg_wr_en),
			.step      (step),
			.smp       (smp),
			.full      (full),
			.age_lim   (age_lim_q),
			.fill_in   (l_fill),
			.del_in    (del_chain[i]),
			.left_val  (l_val),
			.left_age  (l_age),
			.left_flg  (l_flg),
			.right_val (r_val),
			.right_age (r_age),
			.right_flg (r_flg),
			.val       (cell_val[i]),
			.age       (cell_age[i]),
			.flg       (cell_flg[i]),
			.del_out   (del_chain[i+1])
		);

		assign valid_vec[i] = cell_flg[i].valid;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_q)
		else $error("fill count above window size");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(fill_q))
		else $error("occupied cells disagree with fill count");

	a_one_evict: assert property (@(posedge clk) disable iff (!arst_n)
		step && full |-> (del_chain[N] == 1'b1))
		else $error("full window without exactly one leaving sample");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(pend_s1 && out_valid_q && !median_ready))
		else $error("transaction accepted over a pending result");

	a_pend_set: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> pend_s1)
		else $error("result lost after a filling transaction");

endmodule

`default_nettype wire

FILE: rtl/swm_cell.sv
// one cell of the sorted window: holds a value, its age and a valid bit
// depends on swm_pkg; a row of these cells keeps the window in ascending order
`default_nettype none

module swm_cell
	import swm_pkg::*;
#(
	parameter int SW = 32,
	parameter int AW = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clear,
	input  wire logic              step,
	input  wire logic [SW-1:0]     smp,
	input  wire logic              full,
	input  wire logic [AW-1:0]     age_lim,
	input  wire logic              fill_in,
	input  wire logic              del_in,
	input  wire logic [SW-1:0]     left_val,
	input  wire logic [AW-1:0]     left_age,
	input  wire cell_flags_t       left_flg,
	input  wire logic [SW-1:0]     right_val,
	input  wire logic [AW-1:0]     right_age,
	input  wire cell_flags_t       right_flg,
	output logic [SW-1:0]          val,
	output logic [AW-1:0]          age,
	output cell_flags_t            flg,
	output logic                   del_out
);

	logic              valid_q;
	logic [SW-1:0]     val_q;
	logic [AW-1:0]     age_q;
	logic              stay;
	logic              down;
	logic              up;
	logic              valid_nxt;
	logic [SW-1:0]     val_nxt;
	logic [AW-1:0]     age_nxt;

	always_comb begin
		flg.valid = valid_q;
		flg.gt    = !valid_q || (val_q > smp);
		flg.evict = valid_q && full && (age_q == age_lim);
	end

	assign del_out = del_in | flg.evict;

	// each surviving sample moves by (insert before it) - (delete below it)
	assign stay = valid_q && !flg.evict && (del_in == flg.gt);
	assign down = right_flg.valid && !right_flg.evict && del_out && !right_flg.gt;
	assign up   = left_flg.valid && !left_flg.evict && !del_in && left_flg.gt;

	assign valid_nxt = valid_q || (!full && fill_in);

	always_comb begin
		priority if (stay) begin
			val_nxt = val_q;
			age_nxt = age_q + 1'b1;
		end else if (down) begin
			val_nxt = right_val;
			age_nxt = right_age + 1'b1;
		end else if (up) begin
			val_nxt = left_val;
			age_nxt = left_age + 1'b1;
		end else begin
			val_nxt = smp;
			age_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= valid_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step && valid_nxt) begin
			val_q <= val_nxt;
			age_q <= age_nxt;
		end
	end

	assign val = val_q;
	assign age = age_q;

endmodule

`default_nettype wire
